>>> sv/differential_drive_speed_pid_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the differential drive speed controller checkers
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_SPEED_PID_MACROS_SVH
`define DIFFERENTIAL_DRIVE_SPEED_PID_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DDSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ddsp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddsp_pkg
// Shared types, register codes and constants of the differential drive
// speed controller.
// ---------------------------------------------------------------------------
package ddsp_pkg;

  localparam int unsigned TICKS_PER_SECOND   = 10;
  localparam int unsigned GAIN_FRACTION_BITS = 12;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned DELTA_W  = 17;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned DIR_W    = 3;
  localparam int unsigned SUM_W    = 37;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [GAIN_W-1:0]  KP_RESET      = 16'd819;
  localparam logic [GAIN_W-1:0]  KI_RESET      = 16'd328;
  localparam logic [GAIN_W-1:0]  KD_RESET      = 16'd41;
  localparam logic [LIMIT_W-1:0] TARGET_RESET  = 15'd2500;
  localparam logic [LIMIT_W-1:0] ILIMIT_RESET  = 15'd5000;
  localparam logic [LIMIT_W-1:0] GLITCH_RESET  = 15'd6000;
  localparam logic [DUTY_W-1:0]  MAXDUTY_RESET = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_TARGET  = 3'd3,
    REG_ILIMIT  = 3'd4,
    REG_GLITCH  = 3'd5,
    REG_MAXDUTY = 3'd6
  } ddsp_reg_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_HALT       = 3'd0,
    DIR_FWD        = 3'd1,
    DIR_BWD        = 3'd2,
    DIR_TURN_LEFT  = 3'd3,
    DIR_TURN_RIGHT = 3'd4
  } ddsp_dir_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [LIMIT_W-1:0] target_speed;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] glitch_limit;
    logic [DUTY_W-1:0]  max_duty;
  } ddsp_cfg_t;

  // Stage loads and the per-item controls that stage C needs
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
    logic clear;
    logic drive;
  } ddsp_ctrl_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_right;
    logic signed [DELTA_W-1:0] delta_left;
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [SPEED_W-1:0] speed_left;
    logic [DUTY_W-1:0]         duty_right_reverse;
    logic [DUTY_W-1:0]         duty_right_forward;
    logic [DUTY_W-1:0]         duty_left_reverse;
    logic [DUTY_W-1:0]         duty_left_forward;
  } ddsp_result_t;

endpackage

>>> sv/differential_drive_speed_pid.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// differential_drive_speed_pid
// Differential drive speed controller: per-side speed estimate and PID with
// integral clamp, duties steered onto four H-bridge channels.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the master stalls; two side lanes
// run in parallel through five register stages (delta/speed, average, PID state,
// multiply, merge). Ready runs back combinationally: a master stall holds
// s_axis_tready low at once when every stage is full. Reset clears counts, held
// speeds, integrals and last errors, empties the pipeline and loads the
// configuration registers' defaults.
module differential_drive_speed_pid #(
  parameter int unsigned TicksPerSecond = ddsp_pkg::TICKS_PER_SECOND,
  parameter int unsigned GainFracBits   = ddsp_pkg::GAIN_FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: count_front_left, count_rear_left, count_front_right,
  //        count_rear_right, direction, clear_controller, zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ddsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tdata: duty_left_forward, duty_left_reverse, duty_right_forward,
  //        duty_right_reverse, speed_left, speed_right, delta_left,
  //        delta_right, zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ddsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ddsp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ddsp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = ddsp_pkg::COUNT_W;
  localparam int unsigned LW = ddsp_pkg::LIMIT_W;
  localparam int unsigned DRW = ddsp_pkg::DIR_W;

  ddsp_pkg::ddsp_cfg_t    cfg_d, cfg_q;
  ddsp_pkg::ddsp_ctrl_t   ctrl;
  ddsp_pkg::ddsp_result_t result;

  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q, out_vld_q;
  logic vld_a_d, vld_b_d, vld_c_d, vld_d_d, out_vld_d;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic ld_e;

  logic [DRW-1:0] dir_in, dir_a_q, dir_b_q, dir_c_q, dir_d_q;
  logic           clr_in, clr_a_q, clr_b_q;

  logic [ddsp_pkg::DUTY_W-1:0]         duty_left, duty_right;
  logic signed [ddsp_pkg::SPEED_W-1:0] speed_left, speed_right;
  logic signed [ddsp_pkg::DELTA_W-1:0] delta_left, delta_right;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ddsp_pkg::ddsp_reg_e'(cfg_index_i))
        ddsp_pkg::REG_KP:      cfg_d.kp_gain        = cfg_data_i;
        ddsp_pkg::REG_KI:      cfg_d.ki_gain        = cfg_data_i;
        ddsp_pkg::REG_KD:      cfg_d.kd_gain        = cfg_data_i;
        ddsp_pkg::REG_TARGET:  cfg_d.target_speed   = cfg_data_i[LW-1:0];
        ddsp_pkg::REG_ILIMIT:  cfg_d.integral_limit = cfg_data_i[LW-1:0];
        ddsp_pkg::REG_GLITCH:  cfg_d.glitch_limit   = cfg_data_i[LW-1:0];
        ddsp_pkg::REG_MAXDUTY: cfg_d.max_duty       = cfg_data_i[ddsp_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain        <= ddsp_pkg::KP_RESET;
      cfg_q.ki_gain        <= ddsp_pkg::KI_RESET;
      cfg_q.kd_gain        <= ddsp_pkg::KD_RESET;
      cfg_q.target_speed   <= ddsp_pkg::TARGET_RESET;
      cfg_q.integral_limit <= ddsp_pkg::ILIMIT_RESET;
      cfg_q.glitch_limit   <= ddsp_pkg::GLITCH_RESET;
      cfg_q.max_duty       <= ddsp_pkg::MAXDUTY_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline flow: a stage loads when its successor drains or it is empty
  always_comb begin
    rdy_e = !out_vld_q || m_axis_tready;
    rdy_d = !vld_d_q || rdy_e;
    rdy_c = !vld_c_q || rdy_d;
    rdy_b = !vld_b_q || rdy_c;
    rdy_a = !vld_a_q || rdy_b;

    ctrl.ld_a  = s_axis_tvalid && rdy_a;
    ctrl.ld_b  = vld_a_q && rdy_b;
    ctrl.ld_c  = vld_b_q && rdy_c;
    ctrl.ld_d  = vld_c_q && rdy_d;
    ld_e       = vld_d_q && rdy_e;
    ctrl.clear = clr_b_q;
    ctrl.drive = dir_b_q inside {ddsp_pkg::DIR_FWD, ddsp_pkg::DIR_BWD,
                                 ddsp_pkg::DIR_TURN_LEFT, ddsp_pkg::DIR_TURN_RIGHT};

    vld_a_d   = ctrl.ld_a || (vld_a_q && !ctrl.ld_b);
    vld_b_d   = ctrl.ld_b || (vld_b_q && !ctrl.ld_c);
    vld_c_d   = ctrl.ld_c || (vld_c_q && !ctrl.ld_d);
    vld_d_d   = ctrl.ld_d || (vld_d_q && !ld_e);
    out_vld_d = ld_e || (out_vld_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_d_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_a_q   <= vld_a_d;
      vld_b_q   <= vld_b_d;
      vld_c_q   <= vld_c_d;
      vld_d_q   <= vld_d_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign dir_in = s_axis_tdata[66:64];
  assign clr_in = s_axis_tdata[67];

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_a) begin
      dir_a_q <= dir_in;
      clr_a_q <= clr_in;
    end
    if (ctrl.ld_b) begin
      dir_b_q <= dir_a_q;
      clr_b_q <= clr_a_q;
    end
    if (ctrl.ld_c) begin
      dir_c_q <= dir_b_q;
    end
    if (ctrl.ld_d) begin
      dir_d_q <= dir_c_q;
    end
  end

  ddsp_lane #(
    .TicksPerSecond (TicksPerSecond),
    .GainFracBits   (GainFracBits),
    .NegateSpeed    (1'b1)
  ) u_lane_left (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .count_front_i (s_axis_tdata[CW-1:0]),
    .count_rear_i  (s_axis_tdata[2*CW-1:CW]),
    .duty_o        (duty_left),
    .speed_o       (speed_left),
    .delta_o       (delta_left)
  );

  ddsp_lane #(
    .TicksPerSecond (TicksPerSecond),
    .GainFracBits   (GainFracBits),
    .NegateSpeed    (1'b0)
  ) u_lane_right (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .count_front_i (s_axis_tdata[3*CW-1:2*CW]),
    .count_rear_i  (s_axis_tdata[4*CW-1:3*CW]),
    .duty_o        (duty_right),
    .speed_o       (speed_right),
    .delta_o       (delta_right)
  );

  ddsp_merge u_merge (
    .clk_i         (clk_i),
    .ld_i          (ld_e),
    .dir_i         (ddsp_pkg::ddsp_dir_e'(dir_d_q)),
    .duty_left_i   (duty_left),
    .duty_right_i  (duty_right),
    .speed_left_i  (speed_left),
    .speed_right_i (speed_right),
    .delta_left_i  (delta_left),
    .delta_right_i (delta_right),
    .result_o      (result)
  );

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b000000, result};

endmodule

>>> sv/ddsp_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddsp_lane
// One drive side: count deltas, glitch-filtered wheel speeds, side average
// and PID, in a four-stage pipeline producing the side duty.
// ---------------------------------------------------------------------------
module ddsp_lane #(
  parameter int unsigned TicksPerSecond = ddsp_pkg::TICKS_PER_SECOND,
  parameter int unsigned GainFracBits   = ddsp_pkg::GAIN_FRACTION_BITS,
  parameter bit          NegateSpeed    = 1'b0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  ddsp_pkg::ddsp_ctrl_t                      ctrl_i,
  input  ddsp_pkg::ddsp_cfg_t                       cfg_i,
  input  logic signed [ddsp_pkg::COUNT_W-1:0]       count_front_i,
  input  logic signed [ddsp_pkg::COUNT_W-1:0]       count_rear_i,
  output logic [ddsp_pkg::DUTY_W-1:0]               duty_o,
  output logic signed [ddsp_pkg::SPEED_W-1:0]       speed_o,
  output logic signed [ddsp_pkg::DELTA_W-1:0]       delta_o
);

  localparam int unsigned CW = ddsp_pkg::COUNT_W;
  localparam int unsigned DW = ddsp_pkg::DELTA_W;
  localparam int unsigned SW = ddsp_pkg::SPEED_W;
  localparam int unsigned LW = ddsp_pkg::LIMIT_W;
  localparam int unsigned VW = DW + $clog2(TicksPerSecond + 1) + 1;
  localparam int unsigned AW = ddsp_pkg::SUM_W;
  localparam int unsigned QW = AW - GainFracBits;
  localparam logic signed [VW-1:0] TPS_S = VW'(TicksPerSecond);

  // Wheel state and stage A
  logic signed [CW-1:0] cnt      [2];
  logic signed [CW-1:0] prev_q   [2];
  logic signed [SW-1:0] held_q   [2];
  logic signed [SW-1:0] held_d   [2];
  logic signed [DW-1:0] delta    [2];
  logic signed [DW-1:0] delta_n  [2];
  logic signed [VW-1:0] speed_v  [2];
  logic [VW-1:0]        speed_m  [2];
  logic signed [DW-1:0] delta_a_q[2];

  // Stage B
  logic signed [DW-1:0]   spd_sum, spd_adj;
  logic signed [DW:0]     dlt_sum, dlt_adj;
  logic signed [SW-1:0]   avg_b_d;
  logic [LW-1:0]          mag_b_d;
  logic signed [SW-1:0]   avg_b_q;
  logic signed [DW-1:0]   davg_b_q;
  logic [LW-1:0]          mag_b_q;

  // Stage C and controller state
  logic signed [DW-1:0]   integ_q, integ_base;
  logic signed [DW:0]     last_err_q, last_base;
  logic signed [DW-1:0]   err;
  logic signed [DW:0]     acc_raw, acc_clamp, lim_s, deriv;
  logic signed [DW-1:0]   err_c_q;
  logic signed [SW-1:0]   acc_c_q;
  logic signed [DW:0]     deriv_c_q;
  logic signed [SW-1:0]   avg_c_q;
  logic signed [DW-1:0]   davg_c_q;

  // Stage D
  logic signed [33:0]     prod_p_d, prod_p_q;
  logic signed [32:0]     prod_i_d, prod_i_q;
  logic signed [34:0]     prod_d_d, prod_d_q;
  logic signed [SW-1:0]   avg_d_q;
  logic signed [DW-1:0]   davg_d_q;
  logic signed [AW-1:0]   pid_sum;
  logic [QW-1:0]          pid_quo;

  assign cnt[0] = count_front_i;
  assign cnt[1] = count_rear_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      delta[i]   = $signed({cnt[i][CW-1], cnt[i]}) - $signed({prev_q[i][CW-1], prev_q[i]});
      delta_n[i] = NegateSpeed ? -delta[i] : delta[i];
      speed_v[i] = VW'(delta_n[i]) * TPS_S;
      speed_m[i] = speed_v[i][VW-1] ? VW'(-speed_v[i]) : VW'(speed_v[i]);
      // take the new speed only below the glitch limit, else hold
      held_d[i]  = (speed_m[i] < VW'(cfg_i.glitch_limit)) ? speed_v[i][SW-1:0] : held_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '{default: '0};
      held_q <= '{default: '0};
    end else if (ctrl_i.ld_a) begin
      prev_q <= cnt;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_a) begin
      delta_a_q <= delta;
    end
  end

  // Stage B: averages truncated toward zero, speed magnitude.
  // held_q still holds the stage A item's speeds until stage A reloads.
  always_comb begin
    spd_sum = DW'(held_q[0]) + DW'(held_q[1]);
    spd_adj = spd_sum + DW'(spd_sum[DW-1]);
    avg_b_d = spd_adj[DW-1:1];
    dlt_sum = (DW+1)'(delta_a_q[0]) + (DW+1)'(delta_a_q[1]);
    dlt_adj = dlt_sum + (DW+1)'(dlt_sum[DW]);
    mag_b_d = avg_b_d[SW-1] ? LW'(-avg_b_d) : avg_b_d[LW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_b) begin
      avg_b_q  <= avg_b_d;
      davg_b_q <= dlt_adj[DW:1];
      mag_b_q  <= mag_b_d;
    end
  end

  // Stage C: error, clamped integral, derivative
  always_comb begin
    integ_base = ctrl_i.clear ? '0 : integ_q;
    last_base  = ctrl_i.clear ? '0 : last_err_q;
    err        = $signed({2'b00, cfg_i.target_speed}) - $signed({2'b00, mag_b_q});
    acc_raw    = (DW+1)'(integ_base) + (DW+1)'(err);
    lim_s      = $signed({3'b000, cfg_i.integral_limit});
    if (acc_raw > lim_s) begin
      acc_clamp = lim_s;
    end else if (acc_raw < -lim_s) begin
      acc_clamp = -lim_s;
    end else begin
      acc_clamp = acc_raw;
    end
    deriv = (DW+1)'(err) - last_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else if (ctrl_i.ld_c) begin
      if (ctrl_i.drive) begin
        integ_q    <= acc_clamp[DW-1:0];
        last_err_q <= (DW+1)'(err);
      end else if (ctrl_i.clear) begin
        integ_q    <= '0;
        last_err_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_c) begin
      err_c_q   <= err;
      acc_c_q   <= acc_clamp[SW-1:0];
      deriv_c_q <= deriv;
      avg_c_q   <= avg_b_q;
      davg_c_q  <= davg_b_q;
    end
  end

  // Stage D: one multiplier per term
  assign prod_p_d = 34'($signed({1'b0, cfg_i.kp_gain})) * 34'(err_c_q);
  assign prod_i_d = 33'($signed({1'b0, cfg_i.ki_gain})) * 33'(acc_c_q);
  assign prod_d_d = 35'($signed({1'b0, cfg_i.kd_gain})) * 35'(deriv_c_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_d) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      avg_d_q  <= avg_c_q;
      davg_d_q <= davg_c_q;
    end
  end

  // Sum, floor and clamp; negative sums give zero duty
  always_comb begin
    pid_sum = AW'(prod_p_q) + AW'(prod_i_q) + AW'(prod_d_q);
    pid_quo = pid_sum[AW-1:GainFracBits];
    if (pid_sum[AW-1]) begin
      duty_o = '0;
    end else if (pid_quo > QW'(cfg_i.max_duty)) begin
      duty_o = cfg_i.max_duty;
    end else begin
      duty_o = pid_quo[ddsp_pkg::DUTY_W-1:0];
    end
  end

  assign speed_o = avg_d_q;
  assign delta_o = davg_d_q;

endmodule

>>> sv/ddsp_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddsp_merge
// Steers the two side duties onto the four H-bridge channels and holds the
// finished result in the output register.
// ---------------------------------------------------------------------------
module ddsp_merge (
  input  logic                                  clk_i,
  input  logic                                  ld_i,
  input  ddsp_pkg::ddsp_dir_e                   dir_i,
  input  logic [ddsp_pkg::DUTY_W-1:0]           duty_left_i,
  input  logic [ddsp_pkg::DUTY_W-1:0]           duty_right_i,
  input  logic signed [ddsp_pkg::SPEED_W-1:0]   speed_left_i,
  input  logic signed [ddsp_pkg::SPEED_W-1:0]   speed_right_i,
  input  logic signed [ddsp_pkg::DELTA_W-1:0]   delta_left_i,
  input  logic signed [ddsp_pkg::DELTA_W-1:0]   delta_right_i,
  output ddsp_pkg::ddsp_result_t                result_o
);

  ddsp_pkg::ddsp_result_t res_d, res_q;

  always_comb begin
    res_d                    = '0;
    res_d.speed_left         = speed_left_i;
    res_d.speed_right        = speed_right_i;
    res_d.delta_left         = delta_left_i;
    res_d.delta_right        = delta_right_i;
    case (dir_i)
      ddsp_pkg::DIR_FWD: begin
        res_d.duty_left_forward  = duty_left_i;
        res_d.duty_right_forward = duty_right_i;
      end
      ddsp_pkg::DIR_BWD: begin
        res_d.duty_left_reverse  = duty_left_i;
        res_d.duty_right_reverse = duty_right_i;
      end
      ddsp_pkg::DIR_TURN_LEFT: begin
        res_d.duty_left_reverse  = duty_left_i;
        res_d.duty_right_forward = duty_right_i;
      end
      ddsp_pkg::DIR_TURN_RIGHT: begin
        res_d.duty_left_forward  = duty_left_i;
        res_d.duty_right_reverse = duty_right_i;
      end
      // stop and unused codes: all channels off
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

>>> sv/ddsp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddsp_checker
// Port-level checks on the result stream of the speed controller.
// ---------------------------------------------------------------------------
`include "differential_drive_speed_pid_macros.svh"

module ddsp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ddsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  `DDSP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `DDSP_ASSERT_NOW(a_left_one_way, m_axis_tvalid, m_axis_tdata[9:0] == 10'd0 || m_axis_tdata[19:10] == 10'd0, "left bridge driven both ways")

  `DDSP_ASSERT_NOW(a_right_one_way, m_axis_tvalid, m_axis_tdata[29:20] == 10'd0 || m_axis_tdata[39:30] == 10'd0, "right bridge driven both ways")

  `DDSP_ASSERT_NOW(a_speed_range, m_axis_tvalid, m_axis_tdata[55:40] != 16'h8000 && m_axis_tdata[71:56] != 16'h8000, "side speed out of range")

endmodule

bind differential_drive_speed_pid ddsp_checker u_ddsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
